// File: rtl/core/lkvc_pkg.sv
// Package for the LRU key-value cache: types, widths and constants.
package lkvc_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int KEY_W           = 32;
   localparam int VALUE_W         = 32;
   localparam int CAP_W           = 5;
   localparam int PDATA_W         = 32;
   localparam int PADDR_W         = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register index, taken from paddr above the byte offset
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    req_type;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } cache_req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
   } cache_rsp_type;

   // broadcast to every entry cell for one request
   typedef struct packed {
      logic                      touch;      // key present: make it most recent
      logic                      set_value;  // key present on a set: overwrite value
      logic                      insert;     // new key on a set
      logic                      full;       // store full: reuse the oldest entry
      logic                      evict;      // drop the oldest entry after insertion
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

// File: rtl/core/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// A request is taken on any cycle with start high (busy stays low) and is
// registered; the next cycle compares its key against all MAX_ENTRIES entries
// at once, updates value, valid and age ranks, and registers the result. A get
// therefore returns hit and read_value with rsp_valid high for one cycle,
// from the result register; a set returns nothing. One request per cycle
// is sustained by the parallel compare and rank update.
// The result is not held: the receiver must take it in that cycle. The store
// is empty after reset; capacity (register 0) resets to 16 and should only
// be written while no request is in flight.
module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  lkvc_pkg::cache_req_type           req_item,
   output logic                              rsp_valid,
   output lkvc_pkg::cache_rsp_type           rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lkvc_pkg::PADDR_W-1:0]      paddr,
   input  logic [lkvc_pkg::PDATA_W-1:0]      pwdata,
   output logic [lkvc_pkg::PDATA_W-1:0]      prdata,
   output logic                              pready
);

   localparam int RANK_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W + 1 > lkvc_pkg::CAP_W) ? CNT_W + 1 : lkvc_pkg::CAP_W;

   logic                          req_valid_ff;
   lkvc_pkg::cache_req_type       req_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   lkvc_pkg::cache_rsp_type       rsp_ff;
   lkvc_pkg::cache_rsp_type       rsp_in;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;

   logic [lkvc_pkg::CAP_W-1:0]    capacity;
   lkvc_pkg::cell_cmd_type        cmd;
   logic [MAX_ENTRIES-1:0]        match_vec;
   logic [MAX_ENTRIES-1:0]        valid_vec;
   logic [MAX_ENTRIES-1:0]        free_vec;
   logic [MAX_ENTRIES-1:0]        free_first_vec;
   logic [RANK_W-1:0]             lane_rank [MAX_ENTRIES];
   logic [lkvc_pkg::VALUE_W-1:0]  lane_value [MAX_ENTRIES];
   logic [RANK_W-1:0]             hit_rank;
   logic [RANK_W-1:0]             evict_rank;
   logic [lkvc_pkg::VALUE_W-1:0]  hit_value;
   logic                          hit;
   logic                          is_set;
   logic                          full;
   logic                          cap_over;
   logic                          empty;

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   lkvc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
   end

   // entry array
   assign free_vec       = ~valid_vec;
   assign free_first_vec = free_vec & (~free_vec + MAX_ENTRIES'(1));

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_entry
      lkvc_entry #(
         .MAX_ENTRIES (MAX_ENTRIES)
      ) u_entry (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .hit_rank    (hit_rank),
         .evict_rank  (evict_rank),
         .free_first  (free_first_vec[i]),
         .match       (match_vec[i]),
         .valid       (valid_vec[i]),
         .match_rank  (lane_rank[i]),
         .match_value (lane_value[i])
      );
   end

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_rank  = hit_rank | lane_rank[i];
         hit_value = hit_value | lane_value[i];
      end
   end

   // request decode
   assign hit        = |match_vec;
   assign is_set     = (req_ff.req_type == lkvc_pkg::OP_SET);
   assign full       = (count_ff == CNT_W'(MAX_ENTRIES));
   assign empty      = (count_ff == '0);
   assign cap_over   = (CMP_W'(count_ff) + CMP_W'(1)) > CMP_W'(capacity);
   assign evict_rank = RANK_W'(count_ff - CNT_W'(1));

   always_comb begin
      cmd.touch     = req_valid_ff && hit;
      cmd.set_value = is_set;
      // capacity zero on an empty store: new key is dropped at once
      cmd.insert    = req_valid_ff && is_set && !hit && !(empty && cap_over);
      cmd.full      = full;
      cmd.evict     = !full && cap_over && !empty;
      cmd.key       = req_ff.key;
      cmd.value     = req_ff.value;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert && !cmd.full && !cmd.evict) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in        = req_valid_ff && !is_set;
      rsp_in.hit          = hit;
      rsp_in.read_value   = hit ? hit_value : '1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_vec)))
      else $error("entry count out of step with valid entries");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key present in more than one entry");

   a_get_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !is_set) |=> rsp_valid)
      else $error("get transfer without result");

   a_set_gives_none: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && is_set) |=> !rsp_valid)
      else $error("set transfer produced a result");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.hit) |-> (rsp_item.read_value == '1))
      else $error("miss result value not all ones");

endmodule

// File: rtl/core/lkvc_csr.sv
// APB-style configuration register block holding the capacity.
module lkvc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lkvc_pkg::PADDR_W-1:0]      paddr,
   input  logic [lkvc_pkg::PDATA_W-1:0]      pwdata,
   output logic [lkvc_pkg::PDATA_W-1:0]      prdata,
   output logic                              pready,
   output logic [lkvc_pkg::CAP_W-1:0]        capacity
);

   logic [lkvc_pkg::CAP_W-1:0] capacity_ff;
   logic [lkvc_pkg::CAP_W-1:0] capacity_in;
   logic                       reg_idx;
   logic                       wr_en;

   assign reg_idx  = paddr[lkvc_pkg::PADDR_W-1];
   assign wr_en    = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign capacity = capacity_ff;

   always_comb begin
      capacity_in = capacity_ff;
      prdata      = '0;
      unique case (reg_idx)
         lkvc_pkg::CSR_IDX_CAPACITY: begin
            prdata = lkvc_pkg::PDATA_W'(capacity_ff);
            if (wr_en) begin
               capacity_in = pwdata[lkvc_pkg::CAP_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

endmodule

// File: rtl/core/lkvc_entry.sv
// One cache entry: key, value, valid and age rank with its compare and update logic.
module lkvc_entry #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   localparam int RANK_W     = $clog2(MAX_ENTRIES)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lkvc_pkg::cell_cmd_type                cmd,
   input  logic [RANK_W-1:0]                     hit_rank,
   input  logic [RANK_W-1:0]                     evict_rank,
   input  logic                                  free_first,
   output logic                                  match,
   output logic                                  valid,
   output logic [RANK_W-1:0]                     match_rank,
   output logic [lkvc_pkg::VALUE_W-1:0]          match_value
);

   logic                                valid_ff;
   logic                                valid_in;
   logic [RANK_W-1:0]                   rank_ff;
   logic [RANK_W-1:0]                   rank_in;
   logic signed [lkvc_pkg::KEY_W-1:0]   key_ff;
   logic signed [lkvc_pkg::KEY_W-1:0]   key_in;
   logic signed [lkvc_pkg::VALUE_W-1:0] value_ff;
   logic signed [lkvc_pkg::VALUE_W-1:0] value_in;
   logic                                slot;

   assign match       = valid_ff && (key_ff == cmd.key);
   assign valid       = valid_ff;
   assign match_rank  = match ? rank_ff : '0;
   assign match_value = match ? value_ff : '0;

   assign slot = cmd.insert &&
                 (cmd.full ? (valid_ff && (rank_ff == RANK_W'(MAX_ENTRIES - 1))) : free_first);

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.touch) begin
         if (match) begin
            rank_in = '0;
            if (cmd.set_value) begin
               value_in = cmd.value;
            end
         end else if (valid_ff && (rank_ff < hit_rank)) begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end else if (slot) begin
         valid_in = 1'b1;
         key_in   = cmd.key;
         value_in = cmd.value;
         rank_in  = '0;
      end else if (cmd.insert && valid_ff) begin
         if (cmd.evict && (rank_ff == evict_rank)) begin
            valid_in = 1'b0;
            rank_in  = '0;
         end else begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule
